[sv/smbd_pkg.sv]
package smbd_pkg;

  localparam int RAM_BYTES = 65536;
  localparam int ROM_BYTES = 65536;
  localparam int LANES     = 4;
  localparam int RAM_ROWS  = RAM_BYTES / LANES;
  localparam int ROM_ROWS  = ROM_BYTES / LANES;
  localparam int RAM_ROW_W = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
  localparam int ROM_ROW_W = (ROM_ROWS > 1) ? $clog2(ROM_ROWS) : 1;
  localparam int OFF_W     = 28;
  localparam int BOUND_W   = OFF_W + 1;
  localparam int ROM_LEN_W = 17;

  localparam logic [3:0] RAM_SEGMENT    = 4'd8;
  localparam logic [3:0] ROM_SEGMENT    = 4'd2;
  localparam logic [3:0] PERIPH_SEGMENT = 4'hE;

  // peripheral offsets within the segment
  localparam logic [OFF_W-1:0] P_CONSOLE_A = 28'h9000000;
  localparam logic [OFF_W-1:0] P_ZERO      = 28'h9000004;
  localparam logic [OFF_W-1:0] P_ONE       = 28'h9000008;
  localparam logic [OFF_W-1:0] P_TICK_A    = 28'hFFF000C;
  localparam logic [OFF_W-1:0] P_TICK_B    = 28'hEEE000C;
  localparam logic [OFF_W-1:0] P_CONSOLE_B = 28'hFFF0004;
  localparam logic [OFF_W-1:0] P_SINK      = 28'hFFF0018;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_LOAD   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RANGE      = 3'd1;
  localparam logic [2:0] ST_UNMAPPED   = 3'd2;
  localparam logic [2:0] ST_MISALIGNED = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

  localparam logic [2:0] SZ_BYTE = 3'd1;
  localparam logic [2:0] SZ_HALF = 3'd2;
  localparam logic [2:0] SZ_WORD = 3'd4;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_RAM    = 2'd1;
  localparam logic [1:0] SRC_ROM    = 2'd2;
  localparam logic [1:0] SRC_PERIPH = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [2:0]  size_bytes;
    logic [31:0] write_data;
    logic [31:0] tick_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
    logic        console_valid;
    logic [7:0]  console_char;
  } out_item_t;

  // size and alignment check on the two low offset bits
  function automatic logic [2:0] size_check(logic [1:0] lo, logic [2:0] sz);
    logic [2:0] st;
    st = ST_BAD_SIZE;
    if (sz == SZ_BYTE) st = ST_OK;
    else if (sz == SZ_HALF) st = lo[0] ? ST_MISALIGNED : ST_OK;
    else if (sz == SZ_WORD) st = (lo != 2'd0) ? ST_MISALIGNED : ST_OK;
    return st;
  endfunction

endpackage

[sv/sim_memory_bus_decoder.sv]
// Memory bus decoder of an emulated RISC-V machine.
//
// Input channel (in_valid / in_stall / in_data): one access per beat, a read,
// a write or a single ROM byte load. Output channel (out_valid / out_stall /
// out_data): exactly one result beat per access, in order: read data, status
// and the console character. Configuration channel (cfg_valid / cfg_ready /
// cfg_data) writes rom_length; it is always ready, also during the clear.
//
// Pipeline: the RAM/ROM read and the decode stage register are written when
// the input beat is taken; the result is gathered into the output register
// when the decode stage moves on, which an output stall can hold back.
// Throughput: one beat per cycle when the output does not stall, set by the
// single read port of each byte-lane RAM, read exactly once per access.
//
// Reset: control state clears and a clearing pass zeroes the RAM, one 32-bit
// row (all four byte lanes) per cycle, all RAM_ROWS = 16384 rows. in_stall is
// held high until it is done. ROM content is undefined until loaded.
//
// A stall on the output holds the output register; one more access may then
// sit in the decode stage before in_stall rises.
module sim_memory_bus_decoder
  import smbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ROM_LEN_W-1:0] cfg_data
);

  // decode stage contents
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  src;
    logic [2:0]  size;
    logic [1:0]  lo;
    logic [31:0] pval;
    logic        console_valid;
    logic [7:0]  console_char;
  } stage_t;

  logic [ROM_LEN_W-1:0] rom_length;
  logic                 clearing;
  logic [RAM_ROW_W-1:0] clr_addr;

  logic   s1_valid;
  stage_t s1;
  stage_t dec;
  logic   s1_move;
  logic   in_acc;
  logic   ram_wr;
  logic   rom_wr;

  logic [3:0]         seg;
  logic [OFF_W-1:0]   off;
  logic [BOUND_W-1:0] off_x;
  logic [BOUND_W-1:0] off_end;
  logic [BOUND_W-1:0] ram_bound;
  logic [BOUND_W-1:0] rom_bound;
  logic [BOUND_W-1:0] rom_len_x;

  logic [RAM_ROW_W-1:0] ram_row;
  logic [ROM_ROW_W-1:0] rom_row;

  logic                 ram_we    [LANES];
  logic [RAM_ROW_W-1:0] ram_waddr [LANES];
  logic [7:0]           ram_wdata [LANES];
  logic [7:0]           ram_rdata [LANES];
  logic                 rom_we    [LANES];
  logic [7:0]           rom_rdata [LANES];
  logic [7:0]           lane_byte [LANES];

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = clearing || (s1_valid && !s1_move);
  assign in_acc    = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // address decode and checks
  // ---------------------------------------------------------------------
  assign seg       = in_data.address[31:28];
  assign off       = in_data.address[OFF_W-1:0];
  assign off_x     = {1'b0, off};
  assign off_end   = off_x + BOUND_W'(in_data.size_bytes);
  assign ram_bound = BOUND_W'(RAM_BYTES);
  assign rom_len_x = BOUND_W'(rom_length);
  assign rom_bound = (rom_len_x < BOUND_W'(ROM_BYTES)) ? rom_len_x : BOUND_W'(ROM_BYTES);
  assign ram_row   = off[RAM_ROW_W+1:2];
  assign rom_row   = off[ROM_ROW_W+1:2];

  always_comb begin
    logic [BOUND_W-1:0] bound;
    logic               is_ram;
    dec               = '0;
    dec.status        = ST_OK;
    dec.src           = SRC_NONE;
    dec.size          = in_data.size_bytes;
    dec.lo            = off[1:0];
    ram_wr            = 1'b0;
    rom_wr            = 1'b0;
    is_ram            = (seg == RAM_SEGMENT);
    bound             = is_ram ? ram_bound : rom_bound;
    unique case (in_data.action)
      ACT_READ: begin
        if (seg == RAM_SEGMENT || seg == ROM_SEGMENT) begin
          if (off_x >= bound) begin
            dec.status = ST_RANGE;
          end else begin
            dec.status = size_check(off[1:0], in_data.size_bytes);
            if (dec.status == ST_OK && off_end > bound) dec.status = ST_RANGE;
            if (dec.status == ST_OK) dec.src = is_ram ? SRC_RAM : SRC_ROM;
          end
        end else if (seg == PERIPH_SEGMENT) begin
          priority if (off == P_ZERO) dec.pval = 32'd0;
          else if (off == P_ONE) dec.pval = 32'd1;
          else if (off == P_TICK_A || off == P_TICK_B) dec.pval = in_data.tick_ms;
          else dec.status = ST_UNMAPPED;
          if (dec.status == ST_OK) begin
            dec.status = size_check(off[1:0], in_data.size_bytes);
            if (dec.status == ST_OK) dec.src = SRC_PERIPH;
          end
        end else begin
          dec.status = ST_UNMAPPED;
        end
      end
      ACT_WRITE: begin
        if (is_ram) begin
          if (off_x >= ram_bound) begin
            dec.status = ST_RANGE;
          end else begin
            dec.status = size_check(off[1:0], in_data.size_bytes);
            if (dec.status == ST_OK && off_end > ram_bound) dec.status = ST_RANGE;
            ram_wr = (dec.status == ST_OK);
          end
        end else if (seg == PERIPH_SEGMENT) begin
          if (off == P_CONSOLE_A || off == P_CONSOLE_B) begin
            if (in_data.write_data[7:0] != 8'd0) begin
              dec.console_valid = 1'b1;
              dec.console_char  = in_data.write_data[7:0];
            end
          end else if (off != P_SINK) begin
            dec.status = ST_UNMAPPED;
          end
        end else begin
          dec.status = ST_UNMAPPED;
        end
      end
      ACT_LOAD: begin
        // byte index is the offset whatever the segment
        if (off_x >= BOUND_W'(ROM_BYTES)) dec.status = ST_RANGE;
        else rom_wr = 1'b1;
      end
      ACT_UNUSED: begin
        dec.status = ST_UNMAPPED;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // byte lanes: lane i holds the bytes whose offset ends in i
  // ---------------------------------------------------------------------
  always_comb begin
    logic [1:0]  k;
    logic [31:0] shifted;
    for (int i = 0; i < LANES; i++) begin
      k            = 2'(i) - off[1:0];
      shifted      = in_data.write_data >> {k, 3'b000};
      lane_byte[i] = shifted[7:0];
      ram_we[i]    = clearing || (in_acc && ram_wr && ({1'b0, k} < in_data.size_bytes));
      ram_waddr[i] = clearing ? clr_addr : ram_row;
      ram_wdata[i] = clearing ? 8'd0 : lane_byte[i];
      rom_we[i]    = in_acc && rom_wr && (off[1:0] == 2'(i));
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    smbd_ram #(.WIDTH(8), .DEPTH(RAM_ROWS)) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr[g]),
      .wdata (ram_wdata[g]),
      .re    (in_acc),
      .raddr (ram_row),
      .rdata (ram_rdata[g])
    );

    smbd_ram #(.WIDTH(8), .DEPTH(ROM_ROWS)) u_rom (
      .clk   (clk),
      .we    (rom_we[g]),
      .waddr (rom_row),
      .wdata (in_data.write_data[7:0]),
      .re    (in_acc),
      .raddr (rom_row),
      .rdata (rom_rdata[g])
    );
  end

  // ---------------------------------------------------------------------
  // gather and output register
  // ---------------------------------------------------------------------
  out_item_t res;

  always_comb begin
    logic [1:0]  idx;
    logic [7:0]  b;
    logic [31:0] gathered;
    logic [31:0] mask;
    gathered = '0;
    for (int i = 0; i < LANES; i++) begin
      idx = s1.lo + 2'(i);
      b   = (s1.src == SRC_RAM) ? ram_rdata[idx] : rom_rdata[idx];
      if (3'(i) < s1.size) gathered[8*i +: 8] = b;
    end
    unique case (s1.size)
      SZ_BYTE: mask = 32'h0000_00FF;
      SZ_HALF: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    res               = '0;
    res.status        = s1.status;
    res.console_valid = s1.console_valid;
    res.console_char  = s1.console_char;
    unique case (s1.src)
      SRC_RAM, SRC_ROM: res.read_data = gathered;
      SRC_PERIPH:       res.read_data = s1.pval & mask;
      default:          res.read_data = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_length <= '0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) rom_length <= cfg_data;
      if (clearing) begin
        clr_addr <= clr_addr + RAM_ROW_W'(1);
        if (clr_addr == RAM_ROW_W'(RAM_ROWS - 1)) clearing <= 1'b0;
      end
      if (in_acc) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1 <= dec;
    if (s1_move) out_data <= res;
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_console_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.console_valid |-> out_data.status == ST_OK)
    else $error("console beat with error status");

  a_rdata_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.read_data == 32'd0)
    else $error("read data on failed access");

  a_accept_staged: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted beat lost from decode stage");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == RAM_ROW_W'(RAM_ROWS - 1))
    else $error("RAM clear ended early");

endmodule

[sv/smbd_ram.sv]
module smbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
